FILE: rtl/lufp_pkg.sv
// Shared types and constants for the LU factorization block.
// Used by the channel interfaces, controller, datapath, arithmetic unit and top level.
package lufp_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int CMD_W          = 2;
  localparam int ROW_W          = 3;
  localparam int COL_W          = 3;
  localparam int LOAD_W         = 32;
  localparam int ENTRY_W        = 32;
  localparam int PIVOT_W        = 4;
  localparam int SIZE_W         = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_FACT     = 2'd1,
    CMD_RD_ENTRY = 2'd2,
    CMD_RD_PIVOT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    WS_LOAD,
    WS_RDATA,
    WS_TA,
    WS_ZERO,
    WS_QUOT,
    WS_DIFF,
    WS_PINIT
  } wsrc_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_RESP,
    ST_PINIT,
    ST_COL,
    ST_SRD,
    ST_SCMP,
    ST_SDONE,
    ST_SWRA,
    ST_SWRB,
    ST_SWWA,
    ST_SWWB,
    ST_PVRD,
    ST_PVLD,
    ST_MLRD,
    ST_MLLD,
    ST_DIVGO,
    ST_DIVW,
    ST_UPRB,
    ST_UPRA,
    ST_UPGO,
    ST_UPW
  } state_t;

  typedef struct packed {
    logic  mem_rd;
    logic  mem_wr;
    logic  tgt_piv;
    wsrc_t wsrc;
    logic  lat_a;
    logic  lat_b;
    logic  lat_piv;
    logic  lat_mult;
    logic  mul_go;
    logic  div_go;
    logic  srch_init;
    logic  srch_cmp;
    logic  clr_flags;
    logic  cap_out;
    logic  clr_out;
  } dp_cmd_t;

  typedef struct packed {
    logic arith_done;
    logic piv_zero;
  } dp_stat_t;

endpackage

FILE: rtl/lufp_if.sv
// Valid/ready channel interfaces for command transactions and result transactions.
// Depends on lufp_pkg for field widths.
interface lufp_in_if;
  logic                             valid;
  logic                             ready;
  logic [lufp_pkg::CMD_W-1:0]       command;
  logic [lufp_pkg::ROW_W-1:0]       row_index;
  logic [lufp_pkg::COL_W-1:0]       col_index;
  logic signed [lufp_pkg::LOAD_W-1:0] load_value;

  modport source (output valid, command, row_index, col_index, load_value, input ready);
  modport sink   (input valid, command, row_index, col_index, load_value, output ready);
endinterface

interface lufp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lufp_pkg::ENTRY_W-1:0] entry_value;
  logic [lufp_pkg::PIVOT_W-1:0]        pivot_value;
  logic                                singular;
  logic                                saturated;

  modport source (output valid, entry_value, pivot_value, singular, saturated, input ready);
  modport sink   (input valid, entry_value, pivot_value, singular, saturated, output ready);
endinterface

FILE: rtl/lufp_arith.sv
// Shared serial multiply / divide unit in signed fixed point with saturation.
// Shift-add multiply in VALUE_BITS steps, restoring divide in VALUE_BITS+16 steps.
module lufp_arith #(
  parameter int VALUE_BITS = lufp_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mul_go,
  input  logic                         div_go,
  input  logic signed [VALUE_BITS-1:0] opa,
  input  logic signed [VALUE_BITS-1:0] opb,
  output logic signed [VALUE_BITS-1:0] result,
  output logic                         sat,
  output logic                         done
);
  localparam int VB  = VALUE_BITS;
  localparam int FB  = lufp_pkg::FRAC_BITS;
  localparam int SW  = VB + FB;
  localparam int MW  = 2 * VB;
  localparam int CW  = $clog2(SW + 1);
  localparam logic [MW-1:0] MAXM = (MW'(1) << (VB - 1)) - MW'(1);

  logic          busy_r, fin_r, done_r, is_div_r, neg_r, sat_r;
  logic [CW-1:0] cnt_r;
  logic [VB-1:0] opx_r;
  logic [VB:0]   acc_r;
  logic [SW-1:0] sh_r;
  logic signed [VB-1:0] result_r;

  logic [VB-1:0] mag_a, mag_b;
  logic [VB:0]   mul_sum, div_rem, div_diff;
  logic          div_ge;
  logic [MW-1:0] prod, fin_mag;
  logic [VB:0]   sat_out;

  function automatic logic [VB:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
    logic [VB-1:0] lo;
    lo = mag[VB-1:0];
    if (!neg) begin
      if (mag > MAXM) return {1'b1, 1'b0, {(VB-1){1'b1}}};
      return {1'b0, lo};
    end
    if (mag > MAXM + MW'(1)) return {1'b1, 1'b1, {(VB-1){1'b0}}};
    return {1'b0, (~lo) + VB'(1)};
  endfunction

  assign mag_a = opa[VB-1] ? VB'(-opa) : VB'(opa);
  assign mag_b = opb[VB-1] ? VB'(-opb) : VB'(opb);

  assign mul_sum  = acc_r + (sh_r[0] ? {1'b0, opx_r} : '0);
  assign div_rem  = {acc_r[VB-1:0], sh_r[SW-1]};
  assign div_ge   = div_rem >= {1'b0, opx_r};
  assign div_diff = div_rem - {1'b0, opx_r};
  assign prod     = {acc_r[VB-1:0], sh_r[VB-1:0]};
  assign fin_mag  = is_div_r ? MW'(sh_r) : (prod >> FB);
  assign sat_out  = sat_mag(neg_r, fin_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (mul_go || div_go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go || div_go) begin
      is_div_r <= div_go;
      neg_r    <= opa[VB-1] ^ opb[VB-1];
      acc_r    <= '0;
      if (div_go) begin
        opx_r <= mag_b;
        sh_r  <= {mag_a, FB'(0)};
        cnt_r <= CW'(SW);
      end else begin
        opx_r <= mag_a;
        sh_r  <= SW'(mag_b);
        cnt_r <= CW'(VB);
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (is_div_r) begin
        acc_r <= div_ge ? div_diff : div_rem;
        sh_r  <= {sh_r[SW-2:0], div_ge};
      end else begin
        acc_r <= mul_sum >> 1;
        sh_r  <= SW'({mul_sum[0], sh_r[VB-1:1]});
      end
    end
    if (fin_r) begin
      result_r <= sat_out[VB-1:0];
      sat_r    <= sat_out[VB];
    end
  end

  assign result = result_r;
  assign sat    = sat_r;
  assign done   = done_r;
endmodule

FILE: rtl/lufp_dp.sv
// Datapath: matrix and permutation memories, operand registers, pivot search,
// saturating subtract, flags and result registers. Uses lufp_pkg and lufp_arith.
module lufp_dp #(
  parameter int MAX_DIM    = lufp_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = lufp_pkg::VALUE_BITS_DEF,
  parameter int AIW        = $clog2(MAX_DIM)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lufp_pkg::dp_cmd_t                   cmd,
  input  logic [AIW-1:0]                      row_a,
  input  logic [AIW-1:0]                      col_a,
  input  logic signed [lufp_pkg::LOAD_W-1:0]  load_value,
  output lufp_pkg::dp_stat_t                  stat,
  output logic [AIW-1:0]                      best_row,
  output logic signed [lufp_pkg::ENTRY_W-1:0] entry_value,
  output logic [lufp_pkg::PIVOT_W-1:0]        pivot_value,
  output logic                                singular,
  output logic                                saturated
);
  localparam int VB    = VALUE_BITS;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PIV_W = $clog2(MAX_DIM + 1);
  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (VB - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

  logic signed [VB-1:0] mat_mem [DEPTH];
  logic [PIV_W-1:0]     piv_mem [MAX_DIM];

  logic signed [VB-1:0] mat_rd_r, ta_r, tb_r, piv_r, mult_r;
  logic [PIV_W-1:0]     piv_rd_r;
  logic                 rd_tgt_r, piv_zero_r, sing_r, satf_r;
  logic [VB-1:0]        best_mag_r;
  logic [AIW-1:0]       best_r;
  logic signed [lufp_pkg::ENTRY_W-1:0] entry_r;
  logic [lufp_pkg::PIVOT_W-1:0]        pivot_r;

  logic [AW-1:0]        mat_addr;
  logic signed [VB-1:0] rdata, mat_wdata, load_clip, diff_sat, arith_res, opa, opb;
  logic [PIV_W-1:0]     piv_wdata;
  logic [VB-1:0]        rd_mag;
  logic signed [VB:0]   dwide;
  logic                 dovf, arith_sat, arith_done;
  logic signed [63:0]   lv64;

  assign mat_addr = AW'(row_a) * AW'(MAX_DIM) + AW'(col_a);
  assign rdata    = rd_tgt_r ? VB'({1'b0, piv_rd_r}) : mat_rd_r;
  assign rd_mag   = rdata[VB-1] ? VB'(-rdata) : VB'(rdata);

  // Narrow the load value to the store width; this clipping raises no flag.
  assign lv64      = 64'(load_value);
  assign load_clip = (lv64 > VMAX64) ? VB'(VMAX64) :
                     (lv64 < VMIN64) ? VB'(VMIN64) : VB'(lv64);

  assign dwide    = {ta_r[VB-1], ta_r} - {arith_res[VB-1], arith_res};
  assign dovf     = dwide[VB] != dwide[VB-1];
  assign diff_sat = dovf ? {dwide[VB], {(VB-1){~dwide[VB]}}} : dwide[VB-1:0];

  assign opa = cmd.div_go ? ta_r  : mult_r;
  assign opb = cmd.div_go ? piv_r : tb_r;

  lufp_arith #(.VALUE_BITS(VALUE_BITS)) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .mul_go (cmd.mul_go),
    .div_go (cmd.div_go),
    .opa    (opa),
    .opb    (opb),
    .result (arith_res),
    .sat    (arith_sat),
    .done   (arith_done)
  );

  always_comb begin
    case (cmd.wsrc)
      lufp_pkg::WS_LOAD:  mat_wdata = load_clip;
      lufp_pkg::WS_RDATA: mat_wdata = rdata;
      lufp_pkg::WS_TA:    mat_wdata = ta_r;
      lufp_pkg::WS_QUOT:  mat_wdata = arith_res;
      lufp_pkg::WS_DIFF:  mat_wdata = diff_sat;
      default:            mat_wdata = '0;
    endcase
    case (cmd.wsrc)
      lufp_pkg::WS_PINIT: piv_wdata = PIV_W'(row_a) + PIV_W'(1);
      lufp_pkg::WS_RDATA: piv_wdata = rdata[PIV_W-1:0];
      lufp_pkg::WS_TA:    piv_wdata = ta_r[PIV_W-1:0];
      default:            piv_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && !cmd.tgt_piv) mat_mem[mat_addr] <= mat_wdata;
    if (cmd.mem_wr && cmd.tgt_piv)  piv_mem[row_a] <= piv_wdata;
    if (cmd.mem_rd) begin
      mat_rd_r <= mat_mem[mat_addr];
      piv_rd_r <= piv_mem[row_a];
      rd_tgt_r <= cmd.tgt_piv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_a)    ta_r   <= rdata;
    if (cmd.lat_b)    tb_r   <= rdata;
    if (cmd.lat_mult) mult_r <= arith_res;
    if (cmd.lat_piv) begin
      piv_r      <= rdata;
      piv_zero_r <= rdata == '0;
    end
    if (cmd.srch_init) begin
      best_mag_r <= '0;
      best_r     <= row_a;
    end else if (cmd.srch_cmp && rd_mag > best_mag_r) begin
      best_mag_r <= rd_mag;
      best_r     <= row_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sing_r  <= 1'b0;
      satf_r  <= 1'b0;
      entry_r <= '0;
      pivot_r <= '0;
    end else begin
      if (cmd.clr_flags) begin
        sing_r <= 1'b0;
        satf_r <= 1'b0;
      end else begin
        if (cmd.lat_piv && rdata == '0) sing_r <= 1'b1;
        if ((arith_done && arith_sat) ||
            (cmd.mem_wr && cmd.wsrc == lufp_pkg::WS_DIFF && dovf)) satf_r <= 1'b1;
      end
      if (cmd.clr_out) begin
        entry_r <= '0;
        pivot_r <= '0;
      end else if (cmd.cap_out) begin
        if (rd_tgt_r) pivot_r <= lufp_pkg::PIVOT_W'(piv_rd_r);
        else          entry_r <= lufp_pkg::ENTRY_W'(mat_rd_r);
      end
    end
  end

  assign stat.arith_done = arith_done;
  assign stat.piv_zero   = piv_zero_r;
  assign best_row        = best_r;
  assign entry_value     = entry_r;
  assign pivot_value     = pivot_r;
  assign singular        = sing_r;
  assign saturated       = satf_r;
endmodule

FILE: rtl/lufp_ctrl.sv
// Controller: command decode, loop counters and sequencing of the factorization.
// Drives the datapath through lufp_pkg::dp_cmd_t and reads lufp_pkg::dp_stat_t.
module lufp_ctrl #(
  parameter int MAX_DIM = lufp_pkg::MAX_DIM_DEF,
  parameter int AIW     = $clog2(MAX_DIM)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lufp_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lufp_pkg::CMD_W-1:0]    in_command,
  input  logic [lufp_pkg::ROW_W-1:0]    in_row,
  input  logic [lufp_pkg::COL_W-1:0]    in_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lufp_pkg::dp_cmd_t             cmd,
  input  lufp_pkg::dp_stat_t            stat,
  input  logic [AIW-1:0]                best_row,
  output logic [AIW-1:0]                row_a,
  output logic [AIW-1:0]                col_a
);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  lufp_pkg::state_t            state_r, state_nxt;
  logic [DIM_W-1:0]            i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic [lufp_pkg::SIZE_W-1:0] size_r;
  logic [DIM_W-1:0]            n_eff;
  logic                        row_ok, col_ok, end_col, swap_piv;

  assign n_eff  = (size_r == '0) ? DIM_W'(1) :
                  (32'(size_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(size_r);
  assign row_ok = 32'(in_row) < MAX_DIM;
  assign col_ok = 32'(in_col) < MAX_DIM;
  assign swap_piv = j_r == n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lufp_pkg::ST_IDLE;
      size_r  <= lufp_pkg::SIZE_RESET;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      n_r     <= DIM_W'(1);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      if (cfg_we) size_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    cmd       = '0;
    row_a     = '0;
    col_a     = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    end_col   = 1'b0;

    unique case (state_r)
      lufp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        row_a    = AIW'(in_row);
        col_a    = AIW'(in_col);
        if (in_valid) begin
          cmd.clr_out = 1'b1;
          state_nxt   = lufp_pkg::ST_RESP;
          unique case (lufp_pkg::cmd_t'(in_command))
            lufp_pkg::CMD_LOAD: begin
              cmd.mem_wr = row_ok && col_ok;
              cmd.wsrc   = lufp_pkg::WS_LOAD;
            end
            lufp_pkg::CMD_FACT: begin
              cmd.clr_flags = 1'b1;
              n_nxt         = n_eff;
              k_nxt         = '0;
              state_nxt     = lufp_pkg::ST_PINIT;
            end
            lufp_pkg::CMD_RD_ENTRY: begin
              if (row_ok && col_ok) begin
                cmd.mem_rd = 1'b1;
                state_nxt  = lufp_pkg::ST_RDWAIT;
              end
            end
            lufp_pkg::CMD_RD_PIVOT: begin
              if (row_ok) begin
                cmd.mem_rd  = 1'b1;
                cmd.tgt_piv = 1'b1;
                state_nxt   = lufp_pkg::ST_RDWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      lufp_pkg::ST_RDWAIT: begin
        cmd.cap_out = 1'b1;
        state_nxt   = lufp_pkg::ST_RESP;
      end
      lufp_pkg::ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = lufp_pkg::ST_IDLE;
      end
      lufp_pkg::ST_PINIT: begin
        row_a       = AIW'(k_r);
        cmd.mem_wr  = 1'b1;
        cmd.tgt_piv = 1'b1;
        cmd.wsrc    = lufp_pkg::WS_PINIT;
        if (k_r + DIM_W'(1) == n_r) begin
          i_nxt     = '0;
          state_nxt = lufp_pkg::ST_COL;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end
      lufp_pkg::ST_COL: begin
        row_a         = AIW'(i_r);
        cmd.srch_init = 1'b1;
        k_nxt         = i_r;
        state_nxt     = lufp_pkg::ST_SRD;
      end
      lufp_pkg::ST_SRD: begin
        row_a      = AIW'(k_r);
        col_a      = AIW'(i_r);
        cmd.mem_rd = 1'b1;
        state_nxt  = lufp_pkg::ST_SCMP;
      end
      lufp_pkg::ST_SCMP: begin
        row_a        = AIW'(k_r);
        cmd.srch_cmp = 1'b1;
        if (k_r + DIM_W'(1) < n_r) begin
          k_nxt     = k_r + DIM_W'(1);
          state_nxt = lufp_pkg::ST_SRD;
        end else begin
          state_nxt = lufp_pkg::ST_SDONE;
        end
      end
      lufp_pkg::ST_SDONE: begin
        j_nxt     = '0;
        state_nxt = (best_row != AIW'(i_r)) ? lufp_pkg::ST_SWRA : lufp_pkg::ST_PVRD;
      end
      // Swap walks columns 0..n-1, then one more pass for the permutation entry.
      lufp_pkg::ST_SWRA: begin
        row_a       = AIW'(i_r);
        col_a       = AIW'(j_r);
        cmd.mem_rd  = 1'b1;
        cmd.tgt_piv = swap_piv;
        state_nxt   = lufp_pkg::ST_SWRB;
      end
      lufp_pkg::ST_SWRB: begin
        row_a       = best_row;
        col_a       = AIW'(j_r);
        cmd.mem_rd  = 1'b1;
        cmd.tgt_piv = swap_piv;
        cmd.lat_a   = 1'b1;
        state_nxt   = lufp_pkg::ST_SWWA;
      end
      lufp_pkg::ST_SWWA: begin
        row_a       = AIW'(i_r);
        col_a       = AIW'(j_r);
        cmd.mem_wr  = 1'b1;
        cmd.tgt_piv = swap_piv;
        cmd.wsrc    = lufp_pkg::WS_RDATA;
        state_nxt   = lufp_pkg::ST_SWWB;
      end
      lufp_pkg::ST_SWWB: begin
        row_a       = best_row;
        col_a       = AIW'(j_r);
        cmd.mem_wr  = 1'b1;
        cmd.tgt_piv = swap_piv;
        cmd.wsrc    = lufp_pkg::WS_TA;
        if (swap_piv) begin
          state_nxt = lufp_pkg::ST_PVRD;
        end else begin
          j_nxt     = j_r + DIM_W'(1);
          state_nxt = lufp_pkg::ST_SWRA;
        end
      end
      lufp_pkg::ST_PVRD: begin
        row_a      = AIW'(i_r);
        col_a      = AIW'(i_r);
        cmd.mem_rd = 1'b1;
        state_nxt  = lufp_pkg::ST_PVLD;
      end
      lufp_pkg::ST_PVLD: begin
        cmd.lat_piv = 1'b1;
        j_nxt       = i_r + DIM_W'(1);
        if (i_r + DIM_W'(1) < n_r) state_nxt = lufp_pkg::ST_MLRD;
        else                       end_col   = 1'b1;
      end
      lufp_pkg::ST_MLRD: begin
        row_a = AIW'(j_r);
        col_a = AIW'(i_r);
        if (stat.piv_zero) begin
          // Zero pivot: clear the multiplier, leave trailing rows untouched.
          cmd.mem_wr = 1'b1;
          cmd.wsrc   = lufp_pkg::WS_ZERO;
          if (j_r + DIM_W'(1) < n_r) j_nxt   = j_r + DIM_W'(1);
          else                       end_col = 1'b1;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = lufp_pkg::ST_MLLD;
        end
      end
      lufp_pkg::ST_MLLD: begin
        cmd.lat_a = 1'b1;
        state_nxt = lufp_pkg::ST_DIVGO;
      end
      lufp_pkg::ST_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = lufp_pkg::ST_DIVW;
      end
      lufp_pkg::ST_DIVW: begin
        row_a = AIW'(j_r);
        col_a = AIW'(i_r);
        if (stat.arith_done) begin
          cmd.mem_wr   = 1'b1;
          cmd.wsrc     = lufp_pkg::WS_QUOT;
          cmd.lat_mult = 1'b1;
          k_nxt        = i_r + DIM_W'(1);
          state_nxt    = lufp_pkg::ST_UPRB;
        end
      end
      lufp_pkg::ST_UPRB: begin
        row_a      = AIW'(i_r);
        col_a      = AIW'(k_r);
        cmd.mem_rd = 1'b1;
        state_nxt  = lufp_pkg::ST_UPRA;
      end
      lufp_pkg::ST_UPRA: begin
        row_a      = AIW'(j_r);
        col_a      = AIW'(k_r);
        cmd.mem_rd = 1'b1;
        cmd.lat_b  = 1'b1;
        state_nxt  = lufp_pkg::ST_UPGO;
      end
      lufp_pkg::ST_UPGO: begin
        cmd.lat_a  = 1'b1;
        cmd.mul_go = 1'b1;
        state_nxt  = lufp_pkg::ST_UPW;
      end
      lufp_pkg::ST_UPW: begin
        row_a = AIW'(j_r);
        col_a = AIW'(k_r);
        if (stat.arith_done) begin
          cmd.mem_wr = 1'b1;
          cmd.wsrc   = lufp_pkg::WS_DIFF;
          if (k_r + DIM_W'(1) < n_r) begin
            k_nxt     = k_r + DIM_W'(1);
            state_nxt = lufp_pkg::ST_UPRB;
          end else if (j_r + DIM_W'(1) < n_r) begin
            j_nxt     = j_r + DIM_W'(1);
            state_nxt = lufp_pkg::ST_MLRD;
          end else begin
            end_col = 1'b1;
          end
        end
      end
      default: state_nxt = lufp_pkg::ST_IDLE;
    endcase

    // Advance to the next column or finish the factorization.
    if (end_col) begin
      if (i_r + DIM_W'(1) < n_r) begin
        i_nxt     = i_r + DIM_W'(1);
        state_nxt = lufp_pkg::ST_COL;
      end else begin
        state_nxt = lufp_pkg::ST_RESP;
      end
    end
  end
endmodule

FILE: rtl/lu_factorize_partial_pivot.sv
// Top level of the LU factorization block with partial pivoting.
// Depends on lufp_pkg, lufp_if, lufp_ctrl, lufp_dp and lufp_arith.
//
//   channel  | dir | contents
//   ---------+-----+-------------------------------------------------------
//   in_ch    | in  | command, row_index, col_index, load_value (valid/ready)
//   out_ch   | out | entry_value, pivot_value, singular, saturated
//   cfg_*    | in  | cfg_we / cfg_wdata: matrix_size, written when high
//
// One transaction at a time: a command is taken only in idle, its result
// is held on out_ch until taken, then the next command is accepted.
// Load goes from idle straight to the response state; a read adds a wait state.
// Factorize is paced by the one serial multiply/divide unit and the
// single memory port.
// Reset (synchronous, rst_n low) clears control and flags; stores are not cleared.
module lu_factorize_partial_pivot #(
  parameter int MAX_DIM    = lufp_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = lufp_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lufp_in_if.sink                     in_ch,
  lufp_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [lufp_pkg::SIZE_W-1:0] cfg_wdata
);
  localparam int AIW = $clog2(MAX_DIM);

  lufp_pkg::dp_cmd_t  cmd;
  lufp_pkg::dp_stat_t stat;
  logic [AIW-1:0]     best_row, row_a, col_a;

  lufp_ctrl #(.MAX_DIM(MAX_DIM), .AIW(AIW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .in_row     (in_ch.row_index),
    .in_col     (in_ch.col_index),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .stat       (stat),
    .best_row   (best_row),
    .row_a      (row_a),
    .col_a      (col_a)
  );

  lufp_dp #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS), .AIW(AIW)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .row_a       (row_a),
    .col_a       (col_a),
    .load_value  (in_ch.load_value),
    .stat        (stat),
    .best_row    (best_row),
    .entry_value (out_ch.entry_value),
    .pivot_value (out_ch.pivot_value),
    .singular    (out_ch.singular),
    .saturated   (out_ch.saturated)
  );
endmodule

FILE: rtl/lufp_checker.sv
// Port-level checks for lu_factorize_partial_pivot, attached with bind.
// Depends on lufp_pkg for field widths and command codes.
module lufp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [lufp_pkg::CMD_W-1:0]          in_command,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lufp_pkg::ENTRY_W-1:0] entry_value,
  input logic [lufp_pkg::PIVOT_W-1:0]        pivot_value
);
  // A result waits until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("command taken while a result is pending");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_fact_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == lufp_pkg::CMD_FACT |=> !out_valid)
    else $error("factorize result appeared in one cycle");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_value == '0 || pivot_value == '0)
    else $error("entry and pivot both reported");
endmodule

bind lu_factorize_partial_pivot lufp_checker u_lufp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_command  (in_ch.command),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .entry_value (out_ch.entry_value),
  .pivot_value (out_ch.pivot_value)
);
